@@ design/gbn_pkg.sv @@
// Shared types, codes and constants for the go-back-n sender window.
`default_nettype none
package gbn_pkg;

  localparam int WINDOW    = 8;
  localparam int SEQ_SPACE = 32;
  localparam int SEQ_W     = 5;
  localparam int CNT_W     = 4;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 3;
  localparam int TMR_W     = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [TMR_W-1:0] TIMEOUT_RESET = TMR_W'(1000);

  typedef enum logic [OP_W-1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX_NEW  = 3'd0,
    KIND_RETX    = 3'd1,
    KIND_ACK     = 3'd2,
    KIND_REFUSED = 3'd3,
    KIND_IDLE    = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } gbn_cmd_t;

  typedef struct packed {
    logic last;
  } gbn_sts_t;

endpackage
`default_nettype wire

@@ design/gbn_ctrl.sv @@
// Handshake controller: accepts one item, then drives out its result items.
`default_nettype none
module gbn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t      cmd
);
  import gbn_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          // advance through a retransmit run, else return for the next item
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ design/gbn_dp.sv @@
// Window state, retransmit timer and the result register.
`default_nettype none
module gbn_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gbn_pkg::gbn_cmd_t           cmd,
  output gbn_pkg::gbn_sts_t                sts,
  input  wire logic                        cfg_we,
  input  wire logic [gbn_pkg::TMR_W-1:0]   cfg_wdata,
  input  wire logic [gbn_pkg::OP_W-1:0]    op,
  input  wire logic [gbn_pkg::SEQ_W-1:0]   ack_seq,
  output logic [gbn_pkg::KIND_W-1:0]       kind,
  output logic [gbn_pkg::SEQ_W-1:0]        seq,
  output logic [gbn_pkg::CNT_W-1:0]        released,
  output logic [gbn_pkg::CNT_W-1:0]        outstanding,
  output logic                             last
);
  import gbn_pkg::*;

  logic [TMR_W-1:0] timeout_r;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [CNT_W-1:0] flight_r, flight_nxt;
  logic             tmr_on_r, tmr_on_nxt;
  logic [TMR_W-1:0] tmr_cnt_r, tmr_cnt_nxt;

  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [CNT_W-1:0]  rel_r, rel_nxt;
  logic [CNT_W-1:0]  outst_r, outst_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;

  logic [SEQ_W:0]   ack_ext, base_ext, diff_ext, bsum;
  logic [SEQ_W-1:0] ack_gap;
  logic [CNT_W-1:0] rel_cnt, flight_after;
  logic [TMR_W-1:0] tmr_lim, tmr_inc;
  logic [SEQ_W:0]   seq_inc;

  // wrap-aware distance from base to the acked sequence
  always_comb begin
    ack_ext  = {1'b0, ack_seq};
    base_ext = {1'b0, base_r};
    if (ack_ext >= base_ext) begin
      diff_ext = ack_ext - base_ext;
    end else begin
      diff_ext = ack_ext + (SEQ_W+1)'(SEQ_SPACE) - base_ext;
    end
    ack_gap = diff_ext[SEQ_W-1:0];
  end

  always_comb begin
    tmr_lim = (timeout_r == '0) ? TMR_W'(1) : timeout_r;
    tmr_inc = tmr_cnt_r + TMR_W'(1);
    seq_inc = {1'b0, seq_r} + (SEQ_W+1)'(1);
  end

  always_comb begin
    base_nxt    = base_r;
    next_nxt    = next_r;
    flight_nxt  = flight_r;
    tmr_on_nxt  = tmr_on_r;
    tmr_cnt_nxt = tmr_cnt_r;
    kind_nxt    = kind_r;
    seq_nxt     = seq_r;
    rel_nxt     = rel_r;
    outst_nxt   = outst_r;
    last_nxt    = last_r;
    left_nxt    = left_r;
    rel_cnt     = '0;
    flight_after = flight_r;
    bsum        = '0;

    if (cmd.load) begin
      kind_nxt  = KIND_IDLE;
      seq_nxt   = '0;
      rel_nxt   = '0;
      outst_nxt = flight_r;
      last_nxt  = 1'b1;
      left_nxt  = '0;
      unique case (op_t'(op))
        OP_SEND: begin
          if ({1'b0, flight_r} >= (CNT_W+1)'(WINDOW)) begin
            kind_nxt = KIND_REFUSED;
          end else begin
            kind_nxt   = KIND_TX_NEW;
            seq_nxt    = next_r;
            next_nxt   = ({1'b0, next_r} == (SEQ_W+1)'(SEQ_SPACE - 1)) ? '0
                         : next_r + SEQ_W'(1);
            flight_nxt = flight_r + CNT_W'(1);
            outst_nxt  = flight_r + CNT_W'(1);
            if (!tmr_on_r) begin
              tmr_on_nxt  = 1'b1;
              tmr_cnt_nxt = '0;
            end
          end
        end
        OP_ACK: begin
          if ({1'b0, ack_gap} < (SEQ_W+1)'(flight_r)) begin
            rel_cnt = CNT_W'(ack_gap) + CNT_W'(1);
          end
          flight_after = flight_r - rel_cnt;
          bsum = {1'b0, base_r} + (SEQ_W+1)'(rel_cnt);
          if (bsum >= (SEQ_W+1)'(SEQ_SPACE)) begin
            bsum = bsum - (SEQ_W+1)'(SEQ_SPACE);
          end
          base_nxt   = bsum[SEQ_W-1:0];
          flight_nxt = flight_after;
          kind_nxt   = KIND_ACK;
          rel_nxt    = rel_cnt;
          outst_nxt  = flight_after;
          if (!tmr_on_r && flight_after != '0) begin
            tmr_on_nxt  = 1'b1;
            tmr_cnt_nxt = '0;
          end
        end
        OP_TICK: begin
          if (tmr_on_r) begin
            if (tmr_inc < tmr_lim) begin
              tmr_cnt_nxt = tmr_inc;
            end else begin
              // expiry: restart only when entries remain, replay from base
              tmr_cnt_nxt = '0;
              tmr_on_nxt  = (flight_r != '0);
              if (flight_r != '0) begin
                kind_nxt = KIND_RETX;
                seq_nxt  = base_r;
                last_nxt = (flight_r == CNT_W'(1));
                left_nxt = flight_r - CNT_W'(1);
              end
            end
          end
        end
        OP_RSVD: begin
          kind_nxt = KIND_IDLE;
        end
        default: kind_nxt = KIND_IDLE;
      endcase
    end else if (cmd.step) begin
      // next retransmit of the run
      seq_nxt  = (seq_inc >= (SEQ_W+1)'(SEQ_SPACE)) ? '0 : seq_inc[SEQ_W-1:0];
      left_nxt = left_r - CNT_W'(1);
      last_nxt = (left_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      base_r    <= '0;
      next_r    <= '0;
      flight_r  <= '0;
      tmr_on_r  <= 1'b0;
      tmr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      base_r    <= base_nxt;
      next_r    <= next_nxt;
      flight_r  <= flight_nxt;
      tmr_on_r  <= tmr_on_nxt;
      tmr_cnt_r <= tmr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    seq_r   <= seq_nxt;
    rel_r   <= rel_nxt;
    outst_r <= outst_nxt;
    last_r  <= last_nxt;
    left_r  <= left_nxt;
  end

  assign kind        = kind_r;
  assign seq         = seq_r;
  assign released    = rel_r;
  assign outstanding = outst_r;
  assign last        = last_r;
  assign sts.last    = last_r;

endmodule
`default_nettype wire

@@ design/go_back_n_sender_window.sv @@
// Top level of the go-back-n sender window: stream ports, controller and datapath.
//
// Go-Back-N sender window control. Each input item is a send offer, a
// cumulative ack or a timer tick; the block tracks the oldest unacked
// sequence, the next sequence, the count in flight (window 8, sequence
// space 32) and a retransmit timer of cfg_wdata ticks (reset 1000, zero
// acts as one). Every item yields one result item, except a timer expiry
// with entries outstanding, which yields one retransmit item per entry,
// oldest first, with tlast on the final one. Items are handled one at a
// time: the item is taken, its results are loaded into the output
// register, and each result is held until taken; a new item is not
// accepted until the last result item of the one before has been taken.
// The controller state machine sequences these steps; the datapath
// computes each ack release and each timer update combinationally and
// registers it when the item is taken. Write the timeout register only
// while the block is idle.
`default_nettype none
module go_back_n_sender_window (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: timeout_ticks
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [4:0] ack_seq, [7:5] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [4:0] seq, [8:5] released, [12:9] outstanding
  output logic [2:0]       out_tuser,  // [2:0] kind
  output logic             out_tlast
);
  import gbn_pkg::*;

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  logic [SEQ_W-1:0] res_seq;
  logic [CNT_W-1:0] res_rel;
  logic [CNT_W-1:0] res_outst;

  gbn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gbn_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .op          (in_tuser),
    .ack_seq     (in_tdata[4:0]),
    .kind        (out_tuser),
    .seq         (res_seq),
    .released    (res_rel),
    .outstanding (res_outst),
    .last        (out_tlast)
  );

  // pack result fields, lowest field first, pad to whole bytes
  assign out_tdata = {3'b000, res_outst, res_rel, res_seq};

endmodule
`default_nettype wire
